// ===== rtl/pmeds_pkg.sv =====
// shared types and constants for the point-mass euler drag step unit
package pmeds_pkg;

   localparam int FracBitsDefault = 16;
   localparam int WordBitsDefault = 32;
   localparam int CsrIndexBits    = 3;
   localparam int CsrDataBits     = 32;

   typedef enum logic [1:0] {
      OP_APPLY_FORCE   = 2'd0,
      OP_STEP          = 2'd1,
      OP_LOAD_VELOCITY = 2'd2,
      OP_LOAD_POSE     = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_INVERSE_MASS = 3'd0,
      CSR_DRAG_COEFF   = 3'd1,
      CSR_GRAVITY_FAC  = 3'd2,
      CSR_AIR_DENSITY  = 3'd3,
      CSR_GRAVITY_X    = 3'd4,
      CSR_GRAVITY_Y    = 3'd5,
      CSR_ANGULAR_RATE = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQRT,
      ST_MUL,
      ST_DONE
   } state_type;

   // multiplier command: operand a, operand b, shift mode
   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
      logic               half;
      logic               raw;
   } mul_cmd_type;

endpackage

// ===== rtl/pmeds_mul.sv =====
// shared signed multiplier with floored fixed-point shift and saturation
module pmeds_mul #(
   parameter int FRAC_BITS = pmeds_pkg::FracBitsDefault,
   parameter int WORD_BITS = pmeds_pkg::WordBitsDefault
) (
   input  logic                   clock,
   input  pmeds_pkg::mul_cmd_type cmd,
   output logic signed [31:0]     result_q,
   output logic                   clip_q,
   output logic [65:0]            raw_q
);
   import pmeds_pkg::*;

   localparam int SatBits = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam logic signed [65:0] SatMax = (66'sd1 <<< (SatBits - 1)) - 66'sd1;
   localparam logic signed [65:0] SatMin = -SatMax - 66'sd1;

   logic signed [65:0] prod;
   logic signed [65:0] shifted;

   always_comb begin
      prod = 66'(cmd.a) * 66'(cmd.b);
      // arithmetic shift floors toward minus infinity
      if (cmd.half) begin
         shifted = prod >>> (FRAC_BITS + 1);
      end else begin
         shifted = prod >>> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      raw_q <= prod;
      if (shifted > SatMax) begin
         result_q <= 32'(SatMax);
         clip_q   <= 1'b1;
      end else if (shifted < SatMin) begin
         result_q <= 32'(SatMin);
         clip_q   <= 1'b1;
      end else begin
         result_q <= 32'(shifted);
         clip_q   <= 1'b0;
      end
   end

endmodule

// ===== rtl/pmeds_sqrt.sv =====
// bit-serial integer square root, one result bit per cycle
module pmeds_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        busy,
   output logic [31:0] root
);
   import pmeds_pkg::*;

   logic [63:0] rad_ff, rad_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [33:0] part;
   logic [33:0] trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      // next two radicand bits join the remainder and are tried against (4*root + 1)
      part  = {rem_ff, rad_ff[63:62]};
      trial = {res_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         res_in  = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
         // remainder stays below 2^32 until the last bit, which is never reused
         if (part >= trial) begin
            rem_in = 32'(part - trial);
            res_in = {res_ff[30:0], 1'b1};
         end else begin
            rem_in = 32'(part);
            res_in = {res_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign busy = busy_ff;
   assign root = res_ff;

endmodule

// ===== rtl/point_mass_euler_drag_step_unit.sv =====
// top level: operation sequencer, state registers and config registers
//
// One request at a time. apply_force, load_velocity and load_pose put their result
// out the cycle after acceptance. A step runs two squaring passes, a bit-serial
// square root whose root is then picked up, and 14 products through the single
// shared multiplier, each issued and then written back (the four drag products
// are skipped at zero speed); a done state then loads the output register.
// The result is held in that register until taken; the next request is taken the
// cycle after the result has left.
module point_mass_euler_drag_step_unit #(
   parameter int FRAC_BITS = pmeds_pkg::FracBitsDefault,
   parameter int WORD_BITS = pmeds_pkg::WordBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   // arg_x[31:0], arg_y[63:32], arg_angle[95:64], time_step[112:96]
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, heading, vel_x, vel_y (32 bits each from bit 0), saturated[160]
   output logic [167:0] rsp_tdata,
   input  logic         csr_wen,
   input  logic [pmeds_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [pmeds_pkg::CsrDataBits-1:0]  csr_wdata
);
   import pmeds_pkg::*;

   localparam int SatBits = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam logic signed [33:0] SatMax = (34'sd1 <<< (SatBits - 1)) - 34'sd1;
   localparam logic signed [33:0] SatMin = -SatMax - 34'sd1;
   localparam logic [4:0] LastMul = 5'd13;

   // config registers
   logic [30:0]        inv_mass_ff, drag_coef_ff, air_dens_ff;
   logic signed [31:0] grav_fac_ff, grav_x_ff, grav_y_ff, ang_rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff  <= 31'(1) << FRAC_BITS;
         drag_coef_ff <= 31'(1) << FRAC_BITS;
         grav_fac_ff  <= 32'(1) << FRAC_BITS;
         air_dens_ff  <= '0;
         grav_x_ff    <= '0;
         grav_y_ff    <= '0;
         ang_rate_ff  <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_INVERSE_MASS: inv_mass_ff  <= csr_wdata[30:0];
            CSR_DRAG_COEFF:   drag_coef_ff <= csr_wdata[30:0];
            CSR_GRAVITY_FAC:  grav_fac_ff  <= csr_wdata;
            CSR_AIR_DENSITY:  air_dens_ff  <= csr_wdata[30:0];
            CSR_GRAVITY_X:    grav_x_ff    <= csr_wdata;
            CSR_GRAVITY_Y:    grav_y_ff    <= csr_wdata;
            CSR_ANGULAR_RATE: ang_rate_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      if (v > SatMax) return 32'(SatMax);
      if (v < SatMin) return 32'(SatMin);
      return 32'(v);
   endfunction

   function automatic logic clip34(input logic signed [33:0] v);
      return (v > SatMax) || (v < SatMin);
   endfunction

   // request fields
   opcode_type         op;
   logic signed [31:0] in_x, in_y, in_a;
   logic [16:0]        in_dt;
   assign op    = opcode_type'(req_tuser);
   assign in_x  = req_tdata[31:0];
   assign in_y  = req_tdata[63:32];
   assign in_a  = req_tdata[95:64];
   assign in_dt = req_tdata[112:96];

   // body state
   logic signed [31:0] px_ff, py_ff, rot_ff, vx_ff, vy_ff, fx_ff, fy_ff;
   logic signed [31:0] px_in, py_in, rot_in, vx_in, vy_in, fx_in, fy_in;
   // step scratch
   logic signed [31:0] len_ff, k_ff, t1_ff, t2_ff, dx_ff, dy_ff, dx_in, dy_in;
   logic signed [31:0] len_in, k_in, t1_in, t2_in;
   logic [63:0]        sq_ff, sq_in;
   logic [16:0]        dt_ff, dt_in;
   logic [4:0]         idx_ff, idx_in;
   logic               phase_ff, phase_in;
   logic               clip_ff, clip_in;
   logic               out_valid_ff, out_valid_in;
   logic [160:0]       out_ff, out_in;
   state_type          state_ff, state_in;

   mul_cmd_type        mcmd;
   logic signed [31:0] mres;
   logic               mclip;
   logic [65:0]        mraw;
   logic               sq_start, sq_busy;
   logic [31:0]        sq_root;

   pmeds_mul #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_mul (
      .clock(clock), .cmd(mcmd), .result_q(mres), .clip_q(mclip), .raw_q(mraw)
   );

   // the root starts on the full sum of squares as it is written back
   pmeds_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_in),
      .busy(sq_busy), .root(sq_root)
   );

   logic accept;
   assign req_tready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && op == OP_STEP) state_in = ST_SQ;
         ST_SQ:   if (idx_ff == 5'd1 && phase_ff) state_in = ST_SQRT;
         ST_SQRT: if (!sq_start && !sq_busy) state_in = ST_MUL;
         ST_MUL:  if (idx_ff == LastMul && phase_ff) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // multiplier operand selection for each product of a step
   always_comb begin
      mcmd = '{a: '0, b: '0, half: 1'b0, raw: 1'b0};
      case (state_ff)
         ST_SQ: begin
            mcmd.raw = 1'b1;
            if (idx_ff == 5'd0) begin
               mcmd.a = 33'(vx_ff); mcmd.b = 33'(vx_ff);
            end else begin
               mcmd.a = 33'(vy_ff); mcmd.b = 33'(vy_ff);
            end
         end
         ST_MUL: begin
            case (idx_ff)
               5'd0: begin
                  mcmd.a = 33'({1'b0, air_dens_ff}); mcmd.b = 33'({1'b0, drag_coef_ff});
                  mcmd.half = 1'b1;
               end
               5'd1:  begin mcmd.a = 33'(vx_ff); mcmd.b = 33'({1'b0, len_ff}); end
               5'd2:  begin mcmd.a = 33'(t1_ff); mcmd.b = 33'(k_ff); end
               5'd3:  begin mcmd.a = 33'(vy_ff); mcmd.b = 33'({1'b0, len_ff}); end
               5'd4:  begin mcmd.a = 33'(t1_ff); mcmd.b = 33'(k_ff); end
               5'd5:  begin mcmd.a = 33'(vx_ff); mcmd.b = 33'({1'b0, dt_ff}); end
               5'd6:  begin mcmd.a = 33'(vy_ff); mcmd.b = 33'({1'b0, dt_ff}); end
               5'd7:  begin mcmd.a = 33'(t1_ff); mcmd.b = 33'({1'b0, inv_mass_ff}); end
               5'd8:  begin mcmd.a = 33'(grav_x_ff); mcmd.b = 33'(grav_fac_ff); end
               5'd9:  begin mcmd.a = 33'(t2_ff); mcmd.b = 33'({1'b0, inv_mass_ff}); end
               5'd10: begin mcmd.a = 33'(grav_y_ff); mcmd.b = 33'(grav_fac_ff); end
               5'd11: begin mcmd.a = 33'(t1_ff); mcmd.b = 33'({1'b0, dt_ff}); end
               5'd12: begin mcmd.a = 33'(t2_ff); mcmd.b = 33'({1'b0, dt_ff}); end
               5'd13: begin mcmd.a = 33'(ang_rate_ff); mcmd.b = 33'({1'b0, dt_ff}); end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign sq_start = (state_ff == ST_SQ) && (idx_ff == 5'd1) && phase_ff;

   // datapath update for requests and steps; each product is issued, then written back
   always_comb begin
      logic signed [33:0] s;
      logic               wb;
      px_in = px_ff; py_in = py_ff; rot_in = rot_ff; vx_in = vx_ff; vy_in = vy_ff;
      fx_in = fx_ff; fy_in = fy_ff; len_in = len_ff; k_in = k_ff;
      t1_in = t1_ff; t2_in = t2_ff; dx_in = dx_ff; dy_in = dy_ff;
      sq_in = sq_ff; dt_in = dt_ff; idx_in = idx_ff; phase_in = phase_ff;
      clip_in = clip_ff; out_valid_in = out_valid_ff; out_in = out_ff;
      s = '0;
      wb = phase_ff;

      if (out_valid_ff && rsp_tready) out_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0; phase_in = 1'b0;
            if (accept) begin
               clip_in = 1'b0;
               dt_in   = in_dt;
               dx_in   = '0; dy_in = '0;
               case (op)
                  OP_APPLY_FORCE: begin
                     s = 34'(fx_ff) + 34'(in_x);
                     fx_in = sat34(s); clip_in = clip34(s);
                     s = 34'(fy_ff) + 34'(in_y);
                     fy_in = sat34(s); clip_in = clip_in | clip34(s);
                  end
                  OP_LOAD_VELOCITY: begin
                     vx_in = sat34(34'(in_x)); vy_in = sat34(34'(in_y));
                     clip_in = clip34(34'(in_x)) | clip34(34'(in_y));
                  end
                  OP_LOAD_POSE: begin
                     px_in = sat34(34'(in_x)); py_in = sat34(34'(in_y));
                     rot_in = sat34(34'(in_a));
                     clip_in = clip34(34'(in_x)) | clip34(34'(in_y)) | clip34(34'(in_a));
                  end
                  default: ;
               endcase
               if (op != OP_STEP) begin
                  out_valid_in = 1'b1;
                  out_in = {clip_in, vy_in, vx_in, rot_in, py_in, px_in};
               end
            end
         end
         ST_SQ: begin
            phase_in = !phase_ff;
            if (wb) begin
               if (idx_ff == 5'd0) sq_in = mraw[63:0];
               else sq_in = sq_ff + mraw[63:0];
               idx_in = idx_ff + 5'd1;
            end
         end
         ST_SQRT: begin
            idx_in = '0; phase_in = 1'b0;
            len_in = sq_root;
         end
         ST_MUL: begin
            phase_in = !phase_ff;
            if (wb) begin
               idx_in = idx_ff + 5'd1;
               case (idx_ff)
                  5'd0: begin
                     k_in = mres;
                     // no drag at zero speed: skip the drag products and their clipping
                     if (len_ff == '0) idx_in = 5'd5;
                     else clip_in = clip_ff | mclip;
                  end
                  5'd1, 5'd3: begin t1_in = mres; clip_in = clip_ff | mclip; end
                  5'd2, 5'd4: begin
                     s = -34'(mres);
                     clip_in = clip_ff | mclip | clip34(s);
                     if (idx_ff == 5'd2) dx_in = sat34(s); else dy_in = sat34(s);
                  end
                  5'd5: begin
                     // forces with drag first, then position
                     s = 34'(fx_ff) + 34'(dx_ff);
                     t1_in = sat34(s);
                     clip_in = clip_ff | mclip | clip34(s);
                     s = 34'(fy_ff) + 34'(dy_ff);
                     t2_in = sat34(s);
                     clip_in = clip_in | clip34(s);
                     s = 34'(px_ff) + 34'(mres);
                     px_in = sat34(s); clip_in = clip_in | clip34(s);
                  end
                  5'd6: begin
                     s = 34'(py_ff) + 34'(mres);
                     py_in = sat34(s); clip_in = clip_ff | mclip | clip34(s);
                  end
                  5'd7, 5'd9: begin dx_in = mres; clip_in = clip_ff | mclip; end
                  5'd8: begin
                     s = 34'(dx_ff) + 34'(mres);
                     t1_in = sat34(s); clip_in = clip_ff | mclip | clip34(s);
                  end
                  5'd10: begin
                     s = 34'(dx_ff) + 34'(mres);
                     t2_in = sat34(s); clip_in = clip_ff | mclip | clip34(s);
                  end
                  5'd11: begin
                     s = 34'(vx_ff) + 34'(mres);
                     vx_in = sat34(s); clip_in = clip_ff | mclip | clip34(s);
                  end
                  5'd12: begin
                     s = 34'(vy_ff) + 34'(mres);
                     vy_in = sat34(s); clip_in = clip_ff | mclip | clip34(s);
                  end
                  5'd13: begin
                     s = 34'(rot_ff) + 34'(mres);
                     rot_in = sat34(s); clip_in = clip_ff | mclip | clip34(s);
                     fx_in = '0; fy_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_DONE: begin
            out_valid_in = 1'b1;
            out_in = {clip_ff, vy_ff, vx_ff, rot_ff, py_ff, px_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff <= '0; phase_ff <= 1'b0; clip_ff <= 1'b0;
         px_ff <= '0; py_ff <= '0; rot_ff <= '0; vx_ff <= '0; vy_ff <= '0;
         fx_ff <= '0; fy_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         idx_ff <= idx_in; phase_ff <= phase_in; clip_ff <= clip_in;
         px_ff <= px_in; py_ff <= py_in; rot_ff <= rot_in; vx_ff <= vx_in; vy_ff <= vy_in;
         fx_ff <= fx_in; fy_ff <= fy_in;
      end
      len_ff <= len_in; k_ff <= k_in; t1_ff <= t1_in; t2_ff <= t2_in;
      dx_ff <= dx_in; dy_ff <= dy_in; sq_ff <= sq_in; dt_ff <= dt_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff};

   logic unused_bits;
   assign unused_bits = ^{req_tdata[119:113], mcmd.raw, mraw[65:64]};

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE && !rsp_tvalid))
      else $error("ready while busy");
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_STEP) |=> !req_tready)
      else $error("step did not hold off requests");
   a_force_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (fx_ff == '0 && fy_ff == '0))
      else $error("force not cleared after step");

endmodule
